### src/sdsh_pkg.sv
// ----------------------------------------------------------------------------
// sdsh_pkg - shared types and constants for the segment shifter
// Word types for both channels, phase codes, segment table and the
// two-digit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsh_pkg;

  localparam int unsigned ValueW  = 7;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned WordW   = 16;
  localparam int unsigned PosW    = 4;
  localparam int unsigned PhaseW  = 2;

  localparam logic [ValueW-1:0]  MaxValue     = 7'd99;
  localparam logic [PeriodW-1:0] PeriodReset  = 16'd1000;
  localparam logic [PosW-1:0]    TopBit       = 4'd15;

  // Phase codes of the shift sequencer
  localparam logic [PhaseW-1:0] PhaseIdle  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseData  = 2'd1;
  localparam logic [PhaseW-1:0] PhaseLatch = 2'd2;

  // Command codes
  localparam logic CmdTick = 1'b0;
  localparam logic CmdLoad = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ValueW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic serial_bit;
    logic shift_pulse;
    logic latch_pulse;
  } out_word_t;

  localparam logic [7:0] SegTable [10] = '{
    8'hBB, 8'h0A, 8'h73, 8'h5B, 8'hCA, 8'hD9, 8'hFD, 8'h0B, 8'hFB, 8'hDF
  };

  // Tens digit by reciprocal multiply (exact for 0..99), tens pattern in high byte
  function automatic logic [WordW-1:0] encode_pair(input logic [ValueW-1:0] v);
    logic [14:0]       prod;
    logic [3:0]        tens;
    logic [ValueW-1:0] ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'(tens) * 7'd10);
    return {SegTable[tens], SegTable[ones[3:0]]};
  endfunction

endpackage

`default_nettype wire

### src/sdsh_step.sv
// ----------------------------------------------------------------------------
// sdsh_step - counter, update timer and shift sequencer
// Holds the block state and works out the pin activity for one word in a
// single pass of logic; state advances on the cycle the word is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  sdsh_pkg::in_word_t       item_i,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_data_i,
  output sdsh_pkg::out_word_t      res_o
);
  import sdsh_pkg::*;

  logic [PeriodW-1:0] period_q;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic               running_q, running_d;
  logic [ValueW-1:0]  count_q, count_d;
  logic               ovr_pend_q, ovr_pend_d;
  logic [ValueW-1:0]  ovr_val_q, ovr_val_d;
  logic [WordW-1:0]   word_q, word_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PhaseW-1:0]  phase_q, phase_d;

  always_comb begin
    logic [PeriodW:0]  next_tick;
    logic [ValueW-1:0] shown;
    logic [PhaseW-1:0] phase_v;
    logic [PosW-1:0]   pos_v;
    logic [WordW-1:0]  word_v;

    tick_d     = tick_q;
    running_d  = running_q;
    count_d    = count_q;
    ovr_pend_d = ovr_pend_q;
    ovr_val_d  = ovr_val_q;
    word_d     = word_q;
    pos_d      = pos_q;
    phase_d    = phase_q;
    res_o      = '0;
    next_tick  = {1'b0, tick_q} + 17'd1;
    shown      = ovr_pend_q ? ovr_val_q : count_q;
    phase_v    = phase_q;
    pos_v      = pos_q;
    word_v     = word_q;

    if (en_i) begin
      if (item_i.cmd == CmdLoad) begin
        // out-of-range loads are dropped
        if (item_i.value <= MaxValue) begin
          if (!running_q) begin
            count_d   = item_i.value;
            running_d = 1'b1;
            tick_d    = period_q - 16'd1;
          end else begin
            ovr_val_d  = item_i.value;
            ovr_pend_d = 1'b1;
          end
        end
      end else begin
        if (next_tick >= {1'b0, period_q}) begin
          tick_d = '0;
          if (running_q) begin
            ovr_pend_d = 1'b0;
            count_d    = (count_q >= MaxValue) ? '0 : count_q + 7'd1;
            word_v     = encode_pair(shown);
            phase_v    = PhaseData;
            pos_v      = TopBit;
          end
        end else begin
          tick_d = next_tick[PeriodW-1:0];
        end

        word_d = word_v;
        pos_d  = pos_v;
        unique case (phase_v)
          PhaseData: begin
            res_o.serial_bit  = word_v[pos_v];
            res_o.shift_pulse = 1'b1;
            if (pos_v == '0) begin
              pos_d   = TopBit;
              phase_d = PhaseLatch;
            end else begin
              pos_d   = pos_v - 4'd1;
              phase_d = PhaseData;
            end
          end
          PhaseLatch: begin
            res_o.latch_pulse = 1'b1;
            phase_d           = PhaseIdle;
          end
          default: begin
            phase_d = PhaseIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PeriodReset;
      tick_q     <= '0;
      running_q  <= 1'b0;
      count_q    <= '0;
      ovr_pend_q <= 1'b0;
      ovr_val_q  <= '0;
      word_q     <= '0;
      pos_q      <= TopBit;
      phase_q    <= PhaseIdle;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      tick_q     <= tick_d;
      running_q  <= running_d;
      count_q    <= count_d;
      ovr_pend_q <= ovr_pend_d;
      ovr_val_q  <= ovr_val_d;
      word_q     <= word_d;
      pos_q      <= pos_d;
      phase_q    <= phase_d;
    end
  end

  // once started the counter never stops
  a_running_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |=> running_q) else $error("counter stopped after start");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= MaxValue) && (ovr_val_q <= MaxValue))
    else $error("count or override above 99");

  // the latch pulse follows the last data bit
  a_latch_after_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhaseLatch) |-> (pos_q == TopBit))
    else $error("latch phase with bit position not reloaded");

endmodule

`default_nettype wire

### src/two_digit_counter_segment_shifter_top.sv
// ----------------------------------------------------------------------------
// two_digit_counter_segment_shifter_top - seven-segment shift register driver
// Two-digit counter refreshed every ticks_per_update ticks, shown on two
// seven-segment digits through a serial shift register and latch.
//
// Input channel (in_*): one word per tick or load; cmd selects which.
// Output channel (out_*): exactly one word per input word, giving the data
//   bit, shift pulse and latch pulse for that tick (all zero for a load).
// Config channel (cfg_*): writes ticks_per_update; always ready, write it
//   only while no word is in flight.
// Path: a word accepted into the input register is processed into the
//   result register, which drives out_valid_o.
// Throughput: one word per cycle while out_ready_i is high, set by the single
//   pass of logic between the input register and the result register.
// Reset: counter stopped, period 1000, both registers empty.
// Stall: the result register holds while out_ready_i is low; the input
//   register takes one more word, then in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module two_digit_counter_segment_shifter_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sdsh_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sdsh_pkg::out_word_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);
  import sdsh_pkg::*;

  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t res;
  logic      advance;

  // process the held word when the result register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  sdsh_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (in_word_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_data_i;
    end
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q) else $error("processed word lost");

  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipe");

  a_pulses_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.shift_pulse && out_word_q.latch_pulse))
    else $error("shift and latch pulse in one word");

  a_bit_needs_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.serial_bit) |-> out_word_q.shift_pulse)
    else $error("data bit without shift pulse");

endmodule

`default_nettype wire

### dv/segment_shifter_checker.sv
// ----------------------------------------------------------------------------
// segment_shifter_checker - result checker for the segment shifter
// Watches the input, output and period write channels of the block, predicts
// the pin activity for every accepted input word and compares each result
// word field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_shifter_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  sdsh_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sdsh_pkg::out_word_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [15:0]         cfg_data_i,
  output int                  results_o,
  output int                  errors_o
);
  import sdsh_pkg::*;

  // Shadow copy of the counter and the shift sequencer
  logic [PeriodW-1:0] period;
  logic [PeriodW-1:0] tick_count;
  logic               running;
  logic [ValueW-1:0]  count_val;
  logic               ovr_pending;
  logic [ValueW-1:0]  ovr_value;
  logic [WordW-1:0]   shift_word;
  logic [PosW-1:0]    bit_pos;
  logic [PhaseW-1:0]  phase;

  out_word_t pin_words[$];
  int        seen;
  int        errs;

  function automatic out_word_t advance_display(input in_word_t w);
    out_word_t         pins;
    logic [PeriodW:0]  nxt;
    logic [ValueW-1:0] shown;
    pins = '0;
    if (w.cmd == CmdLoad) begin
      // Out-of-range loads leave everything as it is
      if (w.value <= MaxValue) begin
        if (!running) begin
          count_val  = w.value;
          running    = 1'b1;
          tick_count = period - 16'd1;
        end else begin
          ovr_value   = w.value;
          ovr_pending = 1'b1;
        end
      end
    end else begin
      nxt = {1'b0, tick_count} + 17'd1;
      if (nxt >= {1'b0, period}) begin
        tick_count = '0;
        if (running) begin
          if (ovr_pending) begin
            shown       = ovr_value;
            ovr_pending = 1'b0;
          end else begin
            shown = count_val;
          end
          count_val  = (count_val == MaxValue) ? '0 : count_val + 7'd1;
          shift_word = {SegTable[shown / 7'd10], SegTable[shown % 7'd10]};
          phase      = PhaseData;
          bit_pos    = TopBit;
        end
      end else begin
        tick_count = nxt[PeriodW-1:0];
      end

      if (phase == PhaseData) begin
        pins.serial_bit  = shift_word[bit_pos];
        pins.shift_pulse = 1'b1;
        if (bit_pos == '0) begin
          bit_pos = TopBit;
          phase   = PhaseLatch;
        end else begin
          bit_pos = bit_pos - 4'd1;
        end
      end else if (phase == PhaseLatch) begin
        pins.latch_pulse = 1'b1;
        phase            = PhaseIdle;
      end else begin
        phase = PhaseIdle;
      end
    end
    return pins;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      period      = PeriodReset;
      tick_count  = '0;
      running     = 1'b0;
      count_val   = '0;
      ovr_pending = 1'b0;
      ovr_value   = '0;
      shift_word  = '0;
      bit_pos     = TopBit;
      phase       = PhaseIdle;
      pin_words.delete();
      seen        = 0;
      errs        = 0;
      results_o  <= 0;
      errors_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        period = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        pin_words.push_back(advance_display(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (pin_words.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word, expected none, actual %b",
                   $time, out_data_i);
        end else begin
          want = pin_words.pop_front();
          check_field("serial_bit", want.serial_bit, out_data_i.serial_bit);
          check_field("shift_pulse", want.shift_pulse, out_data_i.shift_pulse);
          check_field("latch_pulse", want.latch_pulse, out_data_i.latch_pulse);
        end
      end
      results_o <= seen;
      errors_o  <= errs;
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the segment shifter
// Drives tick and load words through the block under several update periods,
// including zero, one and the largest, with random gaps on the input side and
// random stalls on the output side. Checking is done by the checker module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sdsh_pkg::*;

  localparam int WordsPerPhase = 95;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int results_seen;
  int error_count;
  int sent_count;

  two_digit_counter_segment_shifter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  segment_shifter_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .results_o   (results_seen),
    .errors_o    (error_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly ticks; loads are mostly in range, some above 99
  function automatic in_word_t random_word();
    in_word_t w;
    w.value = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 3) == 0) begin
      w.cmd = CmdLoad;
      if ($urandom_range(0, 6) != 0) w.value = 7'($urandom_range(0, 99));
    end else begin
      w.cmd = CmdTick;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic issue(input in_word_t w, input bit burst);
    send_word(w);
    hold_off(burst ? 0 : gap_len());
  endtask

  // Stop sending and wait for every predicted word to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen != sent_count) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: runs of ready, some long, broken by short or long stalls
  initial begin
    int run_len;
    int stall_len;
    int roll;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 150)
                                            : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 70) stall_len = $urandom_range(1, 2);
      else if (roll < 95) stall_len = $urandom_range(3, 8);
      else stall_len = $urandom_range(15, 40);
      out_ready <= 1'b0;
      repeat (stall_len) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] periods [10];
    in_word_t    w;
    int          done;
    int          n;
    periods = '{16'd1, 16'd0, 16'd17, 16'd65535, 16'd16, 16'd40, 16'd5, 16'd2,
                16'd18, 16'd0};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    sent_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ticks while stopped, rejected loads, start, two overrides,
    // then a whole shift-out and latch at the reset period
    issue(in_word_t'({CmdTick, 7'd127}), 1'b0);
    issue(in_word_t'({CmdLoad, 7'd127}), 1'b0);
    issue(in_word_t'({CmdLoad, 7'd100}), 1'b0);
    issue(in_word_t'({CmdTick, 7'd0}), 1'b0);
    issue(in_word_t'({CmdLoad, 7'd0}), 1'b0);
    issue(in_word_t'({CmdLoad, 7'd99}), 1'b0);
    issue(in_word_t'({CmdLoad, 7'd55}), 1'b0);
    repeat (19) issue(in_word_t'({CmdTick, 7'($urandom_range(0, 127))}), 1'b0);

    foreach (periods[p]) begin
      drain();
      write_period(periods[p]);
      done = 0;
      n    = 0;
      while (done < WordsPerPhase) begin
        w = random_word();
        send_word(w);
        if (!(w.cmd == CmdLoad && w.value > MaxValue)) done++;
        n++;
        // Hold the sender once until everything in flight has landed
        if (p == 5 && n == 50) drain();
        else hold_off((n < 30) ? 0 : gap_len());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && results_seen == sent_count) begin
      $display("two_digit_counter_segment_shifter_top test passed");
    end else begin
      $display("two_digit_counter_segment_shifter_top test failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("two_digit_counter_segment_shifter_top test failed");
    $finish;
  end

endmodule

### files.f
src/sdsh_pkg.sv
src/sdsh_step.sv
src/two_digit_counter_segment_shifter_top.sv
dv/segment_shifter_checker.sv
dv/testbench.sv
